// ===== hdl/pifd_pkg.sv =====
`timescale 1ns / 1ps

package pifd_pkg;

  // Result status codes, carried on out_tuser.
  typedef logic [2:0] status_t;

  localparam status_t ST_GAP   = 3'd0;
  localparam status_t ST_CAL   = 3'd1;
  localparam status_t ST_BIT   = 3'd2;
  localparam status_t ST_REJ   = 3'd3;
  localparam status_t ST_IGN   = 3'd4;
  localparam status_t ST_SHORT = 3'd5;
  localparam status_t ST_LONG  = 3'd6;

  localparam int TIME_W   = 32;
  localparam int GAP_W    = 14;
  localparam int NORM_W   = 8;
  localparam int COUNT_W  = 5;
  localparam int OUT_DATA_W = 40;

  localparam logic [GAP_W-1:0]   GAP_LIMIT_RESET = 14'd4000;

  // Bit counts at which a byte of the shift register is complete.
  localparam logic [COUNT_W-1:0] CNT_BYTE0 = 5'd6;
  localparam logic [COUNT_W-1:0] CNT_BYTE1 = 5'd14;
  localparam logic [COUNT_W-1:0] CNT_BYTE2 = 5'd22;
  localparam logic [COUNT_W-1:0] CNT_BYTE3 = 5'd30;

  // Received bit 1 (ignition) sits at bit 3 of the shift register after six bits.
  localparam int IGNITION_POS = 3;

endpackage

// ===== hdl/pulse_interval_frame_decoder.sv =====
`timescale 1ns / 1ps

// A result passes the input register, then the result register, where a stall can hold it.
// Throughput: one input transaction per cycle while results are not stalled; the interval, limit
// compare, bit shift and receiver update all settle in the single logic stage between the two registers.
// Reset: synchronous, active low. Both pipeline stages empty, gap_limit returns to 4000,
// the receiver waits for a gap, and all timing and frame state clears to zero.
module pulse_interval_frame_decoder
  import pifd_pkg::*;
#(
  parameter int NORM_SHIFT = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream. in_tdata: edge_time[31:0].
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TIME_W-1:0]     in_tdata,
  // Result stream. out_tdata: bit_value[0], frame_word[32:1], frame_bits[37:33], zero [39:38].
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status[2:0].
  output logic [2:0]            out_tuser,
  // Configuration write: gap_limit.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [GAP_W-1:0]      cfg_data
);

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_RECV  = 2'd1,
    MODE_WAIT  = 2'd2
  } mode_t;

  // Configuration register.
  logic [GAP_W-1:0]  gap_limit_r;

  // Input register stage.
  logic              s1_valid_r;
  logic [TIME_W-1:0] s1_time_r;

  // Receiver state.
  logic [TIME_W-1:0]  prev_time_r;
  mode_t              mode_r, mode_nxt;
  logic [COUNT_W-1:0] bit_count_r, bit_count_nxt;
  logic [NORM_W-1:0]  threshold_r, threshold_nxt;
  logic [NORM_W-1:0]  low_limit_r, low_limit_nxt;
  logic [NORM_W-1:0]  high_limit_r, high_limit_nxt;
  logic [7:0]         shift_byte_r, shift_byte_nxt;
  logic [31:0]        frame_store_r, frame_store_nxt;

  // Result register.
  logic               out_valid_r;
  status_t            status_r, status_nxt;
  logic               bit_value_r, bit_value_nxt;
  logic [31:0]        frame_word_r, frame_word_nxt;
  logic [COUNT_W-1:0] frame_bits_r, frame_bits_nxt;

  logic              advance;
  logic              fire;
  logic [TIME_W-1:0] interval;
  logic [TIME_W-1:0] interval_shr;
  logic [NORM_W-1:0] norm;
  logic              is_gap;
  logic              bitv;

  // The result register frees up when it is empty or being taken this cycle;
  // the input register moves forward whenever the result register can take it.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign interval     = s1_time_r - prev_time_r;
  assign interval_shr = interval >> NORM_SHIFT;
  assign norm         = interval_shr[NORM_W-1:0];
  assign is_gap       = interval > {{(TIME_W-GAP_W){1'b0}}, gap_limit_r};
  assign bitv         = norm > threshold_r;

  always_comb begin
    mode_nxt        = mode_r;
    bit_count_nxt   = bit_count_r;
    threshold_nxt   = threshold_r;
    low_limit_nxt   = low_limit_r;
    high_limit_nxt  = high_limit_r;
    shift_byte_nxt  = shift_byte_r;
    frame_store_nxt = frame_store_r;
    status_nxt      = ST_IGN;
    bit_value_nxt   = 1'b0;
    frame_word_nxt  = '0;
    frame_bits_nxt  = '0;

    if (is_gap) begin
      mode_nxt   = MODE_START;
      status_nxt = ST_GAP;
    end else begin
      unique case (mode_r)
        MODE_START: begin
          // The first interval after a gap calibrates the bit window.
          threshold_nxt   = norm;
          low_limit_nxt   = norm >> 1;
          high_limit_nxt  = norm + (norm >> 1);
          shift_byte_nxt  = '0;
          bit_count_nxt   = '0;
          frame_store_nxt = '0;
          mode_nxt        = MODE_RECV;
          status_nxt      = ST_CAL;
        end
        MODE_RECV: begin
          if (norm < low_limit_r || norm > high_limit_r) begin
            mode_nxt   = MODE_WAIT;
            status_nxt = ST_REJ;
          end else begin
            bit_value_nxt  = bitv;
            shift_byte_nxt = {bitv, shift_byte_r[7:1]};
            bit_count_nxt  = bit_count_r + 1'b1;
            status_nxt     = ST_BIT;
            unique case (bit_count_nxt)
              CNT_BYTE0: begin
                frame_store_nxt[7:0] = shift_byte_nxt;
                // Ignition set means the frame stops after six bits.
                if (shift_byte_nxt[IGNITION_POS]) begin
                  status_nxt     = ST_SHORT;
                  frame_bits_nxt = CNT_BYTE0;
                  frame_word_nxt = frame_store_nxt;
                  mode_nxt       = MODE_WAIT;
                end
              end
              CNT_BYTE1: frame_store_nxt[15:8]  = shift_byte_nxt;
              CNT_BYTE2: frame_store_nxt[23:16] = shift_byte_nxt;
              CNT_BYTE3: begin
                frame_store_nxt[31:24] = shift_byte_nxt;
                status_nxt     = ST_LONG;
                frame_bits_nxt = CNT_BYTE3;
                frame_word_nxt = frame_store_nxt;
                mode_nxt       = MODE_WAIT;
              end
              default: ;
            endcase
          end
        end
        default: begin
          // Waiting for a gap (the unused mode code behaves the same way).
          status_nxt = ST_IGN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r   <= GAP_LIMIT_RESET;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      prev_time_r   <= '0;
      mode_r        <= MODE_WAIT;
      bit_count_r   <= '0;
      threshold_r   <= '0;
      low_limit_r   <= '0;
      high_limit_r  <= '0;
      shift_byte_r  <= '0;
      frame_store_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gap_limit_r <= cfg_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        prev_time_r   <= s1_time_r;
        mode_r        <= mode_nxt;
        bit_count_r   <= bit_count_nxt;
        threshold_r   <= threshold_nxt;
        low_limit_r   <= low_limit_nxt;
        high_limit_r  <= high_limit_nxt;
        shift_byte_r  <= shift_byte_nxt;
        frame_store_r <= frame_store_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_time_r <= in_tdata;
    end
    if (fire) begin
      status_r     <= status_nxt;
      bit_value_r  <= bit_value_nxt;
      frame_word_r <= frame_word_nxt;
      frame_bits_r <= frame_bits_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {2'b00, frame_bits_r, frame_word_r, bit_value_r};

endmodule

// ===== hdl/pifd_checker.sv =====
`timescale 1ns / 1ps

module pifd_checker
  import pifd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [TIME_W-1:0]     in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [2:0]            out_tuser,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [GAP_W-1:0]      cfg_data
);

  // A held result keeps its payload and status.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Frame length matches the frame status.
  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == ST_SHORT) == (out_tdata[37:33] == CNT_BYTE0)) &&
                   ((out_tuser == ST_LONG) == (out_tdata[37:33] == CNT_BYTE3)))
    else $error("frame_bits disagrees with status");

  // No frame word outside a completed frame.
  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_SHORT && out_tuser != ST_LONG |-> out_tdata[32:1] == '0)
    else $error("frame_word set without a frame");

  // Only bit-bearing results may carry a set bit, and a short frame has ignition set.
  a_bit_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_GAP || out_tuser == ST_CAL || out_tuser == ST_REJ ||
                   out_tuser == ST_IGN) |-> !out_tdata[0])
    else $error("bit_value set on a result without a bit");

  a_short_ign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_SHORT |-> out_tdata[1 + IGNITION_POS] &&
                                            out_tdata[32:9] == '0)
    else $error("short frame without ignition or with upper bytes set");

endmodule

bind pulse_interval_frame_decoder pifd_checker u_pifd_checker (.*);
